// File: rtl/difp_pkg.sv
// Shared types and constants for the delimited item frame parser.
// No dependencies; compile first.
package difp_pkg;

  localparam int unsigned LINE_MAX   = 128;
  localparam int unsigned MAX_ITEMS  = 8;
  localparam int unsigned MAX_FIELDS = 4;
  localparam int unsigned FIELD_MAX  = 16;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned INDEX_W  = 3;
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned ERR_W    = 32;
  localparam int unsigned NUM_W    = 17;

  localparam logic [NUM_W-1:0] CODE_SAT = 17'd65536;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_LBR   = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBR   = 8'h5D;

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID     = 2'd0,
    ST_PARSE_ERR = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PH_START,
    PH_BARE,
    PH_ITEM,
    PH_AFTER_ITEM,
    PH_AFTER_SEMI
  } phase_e;

  typedef enum logic [1:0] {
    NUM_LEAD,
    NUM_SIGN,
    NUM_DIGITS,
    NUM_BAD
  } num_e;

  typedef struct packed {
    status_e              status;
    logic [COUNT_W-1:0]   item_count;
    logic                 code_found;
    logic [INDEX_W-1:0]   code_item;
    logic [CODE_W-1:0]    first_code;
    logic [CODE_W-1:0]    second_code;
  } frame_t;

  typedef struct packed {
    logic   valid;
    frame_t data;
  } line_res_t;

endpackage

// File: rtl/difp_ifs.sv
// Channel interfaces: received byte stream and parsed frame results.
// Depends on difp_pkg.
interface difp_byte_if;
  import difp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface difp_frame_if;
  import difp_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  item_count;
  logic                code_found;
  logic [INDEX_W-1:0]  code_item;
  logic [CODE_W-1:0]   first_code;
  logic [CODE_W-1:0]   second_code;
  logic [ERR_W-1:0]    error_total;
  modport source (output valid, output status, output item_count, output code_found,
                  output code_item, output first_code, output second_code,
                  output error_total, input ready);
  modport sink   (input valid, input status, input item_count, input code_found,
                  input code_item, input first_code, input second_code,
                  input error_total, output ready);
endinterface

// File: rtl/difp_line_parser.sv
// Byte-at-a-time line parser: tracks line length, form, fields and numeric codes,
// and produces one line result when LF closes a non-empty line. Depends on difp_pkg.
module difp_line_parser #(
  parameter int unsigned LineMax   = difp_pkg::LINE_MAX,
  parameter int unsigned MaxItems  = difp_pkg::MAX_ITEMS,
  parameter int unsigned MaxFields = difp_pkg::MAX_FIELDS,
  parameter int unsigned FieldMax  = difp_pkg::FIELD_MAX
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [difp_pkg::BYTE_W-1:0]     byte_i,
  output difp_pkg::line_res_t             res_o
);
  import difp_pkg::*;

  localparam int unsigned LlW = $clog2(LineMax);
  localparam int unsigned FsW = $clog2(MaxFields);
  localparam int unsigned FcW = $clog2(FieldMax);
  localparam int unsigned TbW = $clog2(FieldMax + 1);
  localparam int unsigned SumW = TbW + 1;

  typedef struct packed {
    num_e             phase;
    logic             neg;
    logic [NUM_W-1:0] value;
  } num_t;

  localparam num_t NUM_IDLE = '{phase: NUM_LEAD, neg: 1'b0, value: '0};

  function automatic logic num_ok(num_t n);
    return (n.phase == NUM_DIGITS) && !(n.neg && (n.value != '0)) && !n.value[NUM_W-1];
  endfunction

  function automatic num_t num_step(num_t n, logic [BYTE_W-1:0] c, logic gap);
    num_t               r;
    logic               is_dig;
    logic [3:0]         dig;
    logic [NUM_W+2:0]   acc;
    r      = n;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    dig    = 4'(c - CH_ZERO);
    acc    = ({3'b000, n.value} << 3) + ({3'b000, n.value} << 1) + (NUM_W + 3)'(dig);
    case (n.phase)
      NUM_LEAD: begin
        if (c == CH_VT || c == CH_FF) begin
          r.phase = NUM_LEAD;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          r.phase = NUM_SIGN;
          r.neg   = (c == CH_MINUS);
        end else if (is_dig) begin
          r.phase = NUM_DIGITS;
          r.value = NUM_W'(dig);
        end else begin
          r.phase = NUM_BAD;
        end
      end
      NUM_SIGN: begin
        if (!gap && is_dig) begin
          r.phase = NUM_DIGITS;
          r.value = NUM_W'(dig);
        end else begin
          r.phase = NUM_BAD;
        end
      end
      NUM_DIGITS: begin
        if (!gap && is_dig) begin
          r.value = (acc > (NUM_W + 3)'(CODE_SAT)) ? CODE_SAT : NUM_W'(acc);
        end else begin
          r.phase = NUM_BAD;
        end
      end
      default: r.phase = NUM_BAD;
    endcase
    return r;
  endfunction

  logic [LlW-1:0]          len_q, len_d;
  logic                    ovf_q, ovf_d;
  logic                    ended_q, ended_d;
  logic                    fail_q, fail_d;
  phase_e                  phase_q, phase_d;
  logic [COUNT_W-1:0]      items_q, items_d;
  logic [FsW-1:0]          fields_q, fields_d;
  logic [FcW-1:0]          fchars_q, fchars_d;
  logic [TbW-1:0]          trail_q, trail_d;
  num_t                    num_q, num_d;
  logic                    code1_ok_q, code1_ok_d;
  logic [CODE_W-1:0]       code1_q, code1_d;
  logic                    chosen_valid_q, chosen_valid_d;
  logic [INDEX_W-1:0]      chosen_idx_q, chosen_idx_d;
  logic [2*CODE_W-1:0]     chosen_codes_q, chosen_codes_d;

  logic is_blank, is_comma, is_semi, is_lbr, is_rbr, is_cr, is_lf, is_nul;
  logic lf_ev, store, room, pe, in_field, bare_like;
  logic f_close, i_close, f_char, cur_ok, hit_item;
  logic [SumW-1:0] sum;

  assign is_blank = (byte_i == CH_SPACE) || (byte_i == CH_TAB);
  assign is_comma = (byte_i == CH_COMMA);
  assign is_semi  = (byte_i == CH_SEMI);
  assign is_lbr   = (byte_i == CH_LBR);
  assign is_rbr   = (byte_i == CH_RBR);
  assign is_cr    = (byte_i == CH_CR);
  assign is_lf    = (byte_i == CH_LF);
  assign is_nul   = (byte_i == CH_NUL);

  assign lf_ev     = step_i && is_lf;
  assign store     = step_i && !is_cr && !is_lf && !ovf_q;
  assign room      = (len_q != LlW'(LineMax - 1));
  assign pe        = store && room && !ended_q && !fail_q && !is_nul;
  assign bare_like = (phase_q == PH_BARE) || (phase_q == PH_START);
  assign in_field  = (phase_q == PH_BARE) || (phase_q == PH_ITEM) ||
                     ((phase_q == PH_START) && !is_blank && !is_lbr);
  assign f_close   = pe && in_field && is_comma;
  assign i_close   = pe && (phase_q == PH_ITEM) && is_rbr;
  assign f_char    = pe && in_field && !is_comma && !((phase_q == PH_ITEM) && is_rbr) &&
                     !(bare_like && is_semi);
  assign sum       = SumW'(fchars_q) + SumW'(trail_q) + SumW'(1);
  assign cur_ok    = num_ok(num_q);
  assign hit_item  = (fields_q == FsW'(2)) && code1_ok_q && cur_ok;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (lf_ev) begin
      phase_d = PH_START;
    end else if (pe) begin
      unique case (phase_q)
        PH_START: begin
          if (is_lbr) begin
            phase_d = PH_ITEM;
          end else if (!is_blank) begin
            phase_d = PH_BARE;
          end
        end
        PH_ITEM: begin
          if (is_rbr) phase_d = PH_AFTER_ITEM;
        end
        PH_AFTER_ITEM: begin
          if (is_semi) phase_d = PH_AFTER_SEMI;
        end
        PH_AFTER_SEMI: begin
          if (is_lbr) phase_d = PH_ITEM;
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  // Line, field and code state
  always_comb begin
    len_d          = len_q;
    ovf_d          = ovf_q;
    ended_d        = ended_q;
    fail_d         = fail_q;
    items_d        = items_q;
    fields_d       = fields_q;
    fchars_d       = fchars_q;
    trail_d        = trail_q;
    num_d          = num_q;
    code1_ok_d     = code1_ok_q;
    code1_d        = code1_q;
    chosen_valid_d = chosen_valid_q;
    chosen_idx_d   = chosen_idx_q;
    chosen_codes_d = chosen_codes_q;

    if (lf_ev) begin
      len_d          = '0;
      ovf_d          = 1'b0;
      ended_d        = 1'b0;
      fail_d         = 1'b0;
      items_d        = '0;
      fields_d       = '0;
      fchars_d       = '0;
      trail_d        = '0;
      num_d          = NUM_IDLE;
      code1_ok_d     = 1'b0;
      code1_d        = '0;
      chosen_valid_d = 1'b0;
      chosen_idx_d   = '0;
      chosen_codes_d = '0;
    end else begin
      if (store) begin
        if (room) begin
          len_d = len_q + LlW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
      if (store && room && is_nul) ended_d = 1'b1;

      if (f_char) begin
        if (is_blank) begin
          if (fchars_q != '0 && trail_q != TbW'(FieldMax)) trail_d = trail_q + TbW'(1);
        end else begin
          if (sum >= SumW'(FieldMax)) fail_d = 1'b1;
          fchars_d = FcW'(sum);
          trail_d  = '0;
          num_d    = num_step(num_q, byte_i, trail_q != '0);
        end
      end

      if (f_close) begin
        if (fchars_q == '0 || fields_q == FsW'(MaxFields - 1)) fail_d = 1'b1;
        if (fields_q == FsW'(1)) begin
          code1_ok_d = cur_ok;
          code1_d    = num_q.value[CODE_W-1:0];
        end
        fields_d = fields_q + FsW'(1);
        fchars_d = '0;
        trail_d  = '0;
        num_d    = NUM_IDLE;
      end

      if (i_close) begin
        if (fchars_q == '0) fail_d = 1'b1;
        if (hit_item && !chosen_valid_q) begin
          chosen_valid_d = 1'b1;
          chosen_idx_d   = items_q[INDEX_W-1:0];
          chosen_codes_d = {code1_q, num_q.value[CODE_W-1:0]};
        end
        items_d    = items_q + COUNT_W'(1);
        fields_d   = '0;
        fchars_d   = '0;
        trail_d    = '0;
        num_d      = NUM_IDLE;
        code1_ok_d = 1'b0;
      end

      if (pe && bare_like && is_semi) fail_d = 1'b1;
      if (pe && (phase_q == PH_AFTER_ITEM) && !is_blank && !is_semi) fail_d = 1'b1;
      if (pe && (phase_q == PH_AFTER_SEMI) && !is_blank &&
          (!is_lbr || items_q >= COUNT_W'(MaxItems))) fail_d = 1'b1;
    end
  end

  // Line result on LF
  always_comb begin
    logic ok;
    ok = 1'b0;
    res_o = '0;
    res_o.valid = lf_ev && (ovf_q || len_q != '0);
    unique case (phase_q)
      PH_BARE: begin
        ok = !fail_q && (fchars_q != '0);
        res_o.data.item_count = COUNT_W'(1);
        res_o.data.code_found = hit_item;
        res_o.data.code_item  = '0;
        if (hit_item) begin
          res_o.data.first_code  = code1_q;
          res_o.data.second_code = num_q.value[CODE_W-1:0];
        end
      end
      PH_AFTER_ITEM: begin
        ok = !fail_q;
        res_o.data.item_count = items_q;
        res_o.data.code_found = chosen_valid_q;
        if (chosen_valid_q) begin
          res_o.data.code_item   = chosen_idx_q;
          res_o.data.first_code  = chosen_codes_q[2*CODE_W-1:CODE_W];
          res_o.data.second_code = chosen_codes_q[CODE_W-1:0];
        end
      end
      default: ok = 1'b0;
    endcase
    if (ovf_q) begin
      res_o.data        = '0;
      res_o.data.status = ST_OVERFLOW;
    end else if (!ok) begin
      res_o.data        = '0;
      res_o.data.status = ST_PARSE_ERR;
    end else begin
      res_o.data.status = ST_VALID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q          <= '0;
      ovf_q          <= 1'b0;
      ended_q        <= 1'b0;
      fail_q         <= 1'b0;
      phase_q        <= PH_START;
      items_q        <= '0;
      fields_q       <= '0;
      fchars_q       <= '0;
      trail_q        <= '0;
      num_q          <= NUM_IDLE;
      code1_ok_q     <= 1'b0;
      code1_q        <= '0;
      chosen_valid_q <= 1'b0;
      chosen_idx_q   <= '0;
      chosen_codes_q <= '0;
    end else begin
      len_q          <= len_d;
      ovf_q          <= ovf_d;
      ended_q        <= ended_d;
      fail_q         <= fail_d;
      phase_q        <= phase_d;
      items_q        <= items_d;
      fields_q       <= fields_d;
      fchars_q       <= fchars_d;
      trail_q        <= trail_d;
      num_q          <= num_d;
      code1_ok_q     <= code1_ok_d;
      code1_q        <= code1_d;
      chosen_valid_q <= chosen_valid_d;
      chosen_idx_q   <= chosen_idx_d;
      chosen_codes_q <= chosen_codes_d;
    end
  end

endmodule

// File: rtl/delimited_item_frame_parser.sv
// Top level: byte channel in, one frame result per closed non-empty line out.
// Depends on difp_pkg, difp_ifs (difp_byte_if, difp_frame_if) and difp_line_parser.
//
//   channel   dir  modport  payload
//   rx_i      in   sink     in_byte
//   frame_o   out  source   status, item_count, code_found, code_item,
//                           first_code, second_code, error_total
//
// One byte per cycle while rx_i.ready is high. Each byte updates the parser registers; the
// LF that closes a line loads the result register on the same edge, so a result
// shows in the cycle after its LF. The result register is one deep: rx_i.ready drops
// only while a result waits and frame_o.ready is low. Reset clears the line state
// and the error count.
module delimited_item_frame_parser #(
  parameter int unsigned LineMax   = difp_pkg::LINE_MAX,
  parameter int unsigned MaxItems  = difp_pkg::MAX_ITEMS,
  parameter int unsigned MaxFields = difp_pkg::MAX_FIELDS,
  parameter int unsigned FieldMax  = difp_pkg::FIELD_MAX
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  difp_byte_if.sink     rx_i,
  difp_frame_if.source  frame_o
);
  import difp_pkg::*;

  logic             step;
  line_res_t        res;
  logic             out_valid_q, out_valid_d;
  frame_t           out_q;
  logic [ERR_W-1:0] err_q, err_d, err_out_q;
  logic             res_err;

  assign rx_i.ready = !out_valid_q || frame_o.ready;
  assign step       = rx_i.valid && rx_i.ready;

  difp_line_parser #(
    .LineMax  (LineMax),
    .MaxItems (MaxItems),
    .MaxFields(MaxFields),
    .FieldMax (FieldMax)
  ) u_parser (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .byte_i(rx_i.in_byte),
    .res_o (res)
  );

  assign res_err = res.valid && (res.data.status != ST_VALID);
  assign err_d   = res_err ? err_q + ERR_W'(1) : err_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (frame_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      err_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      err_q       <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_q     <= res.data;
      err_out_q <= err_d;
    end
  end

  assign frame_o.valid       = out_valid_q;
  assign frame_o.status      = out_q.status;
  assign frame_o.item_count  = out_q.item_count;
  assign frame_o.code_found  = out_q.code_found;
  assign frame_o.code_item   = out_q.code_item;
  assign frame_o.first_code  = out_q.first_code;
  assign frame_o.second_code = out_q.second_code;
  assign frame_o.error_total = err_out_q;

  a_err_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_err |=> (err_q == $past(err_q) + ERR_W'(1)))
    else $error("error count did not advance on an error result");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !frame_o.ready) |-> !res.valid)
    else $error("result produced while output register is held");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_o.valid && (frame_o.status != ST_VALID)) |->
      (frame_o.item_count == '0 && !frame_o.code_found && frame_o.first_code == '0))
    else $error("error result carries frame data");

  a_code_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_o.valid && frame_o.code_found) |->
      (COUNT_W'(frame_o.code_item) < frame_o.item_count))
    else $error("code item index beyond item count");

endmodule
